/* rtl/tslt_pkg.sv */
// Shared types, field widths and default sizes of the two-level keyed set table.
`timescale 1ns / 1ps

package tslt_pkg;

   localparam int WEEK_SLOTS_DEF       = 16;
   localparam int MOMENTS_PER_WEEK_DEF = 16;

   localparam int REQ_TYPE_W   = 2;
   localparam int WEEK_KEY_W   = 48;
   localparam int MOMENT_KEY_W = 16;
   localparam int REQ_TDATA_W  = WEEK_KEY_W + MOMENT_KEY_W;
   localparam int STATUS_W     = 3;
   localparam int RSP_TDATA_W  = 8;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_INSERT     = 2'd0,
      REQ_DEL_MOMENT = 2'd1,
      REQ_DEL_WEEK   = 2'd2,
      REQ_RESERVED   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE         = 3'd0,
      STS_OCCUPIED     = 3'd1,
      STS_NOT_FOUND    = 3'd2,
      STS_WEEKS_FULL   = 3'd3,
      STS_MOMENTS_FULL = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WSCAN,
      S_MSCAN,
      S_MWIPE,
      S_RESP
   } fsm_state_type;

endpackage

/* rtl/two_level_keyed_set_table.sv */
// Top level of the two-level keyed set table: week slots, each owning a set of moment slots.
`timescale 1ns / 1ps

// Each key memory has a single read port: the week scan reads one week slot per cycle,
// then the moment scan (or the week wipe) visits one moment slot per cycle. A reserved
// request skips the scans and goes straight to the response state.
// One request is in work at a time; its response waits in an output register.
// Reset is synchronous and active high; afterwards a clearing pass over all
// WEEK_SLOTS * MOMENTS_PER_WEEK moment slots marks each one free before the first request.
module two_level_keyed_set_table
   import tslt_pkg::*;
#(
   parameter int WEEK_SLOTS       = WEEK_SLOTS_DEF,
   parameter int MOMENTS_PER_WEEK = MOMENTS_PER_WEEK_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [47:0] week_key, [63:48] moment_key
   input  logic [REQ_TYPE_W-1:0]  req_tuser,  // [1:0] req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [2:0] status, [7:3] zero
);

   // Moment slots of week w live at addresses w*MOMENTS_PER_WEEK onward.
   localparam int MSLOTS  = WEEK_SLOTS * MOMENTS_PER_WEEK;
   localparam int WIDX_W  = (WEEK_SLOTS > 1) ? $clog2(WEEK_SLOTS) : 1;
   localparam int MADDR_W = (MSLOTS > 1) ? $clog2(MSLOTS) : 1;
   localparam int CNT_W   = $clog2(MSLOTS + 1);
   localparam int MWORD_W = MOMENT_KEY_W + 1;

   localparam logic [CNT_W-1:0]   WEEK_CNT   = CNT_W'(WEEK_SLOTS);
   localparam logic [CNT_W-1:0]   WEEK_LAST  = CNT_W'(WEEK_SLOTS - 1);
   localparam logic [CNT_W-1:0]   MOM_CNT    = CNT_W'(MOMENTS_PER_WEEK);
   localparam logic [CNT_W-1:0]   MOM_LAST   = CNT_W'(MOMENTS_PER_WEEK - 1);
   localparam logic [CNT_W-1:0]   CLEAR_LAST = CNT_W'(MSLOTS - 1);
   localparam logic [MADDR_W-1:0] MOM_STRIDE = MADDR_W'(MOMENTS_PER_WEEK);

   // Key memories. A moment word carries its used bit on top of the key.
   logic [WEEK_KEY_W-1:0] week_mem [WEEK_SLOTS];
   logic [MWORD_W-1:0]    moment_mem [MSLOTS];

   // Week used bits sit in flip-flops so that a free slot can be picked during the scan.
   logic week_used_ff [WEEK_SLOTS];

   fsm_state_type         state_ff, state_in;
   req_kind_type          kind_ff, kind_in;
   logic [WEEK_KEY_W-1:0] week_key_ff, week_key_in;
   logic [MOMENT_KEY_W-1:0] moment_key_ff, moment_key_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  free_vld_ff, free_vld_in;
   logic [CNT_W-1:0]      free_idx_ff, free_idx_in;
   logic [MADDR_W-1:0]    base_ff, base_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic [WEEK_KEY_W-1:0] week_rdata_ff;
   logic [MWORD_W-1:0]    moment_rdata_ff;

   // Memory and used-bit controls driven by the sequencer.
   logic                  week_rd_en;
   logic [WIDX_W-1:0]     week_rd_addr;
   logic                  week_we;
   logic [WIDX_W-1:0]     week_waddr;
   logic                  moment_rd_en;
   logic [MADDR_W-1:0]    moment_rd_addr;
   logic                  moment_we;
   logic [MADDR_W-1:0]    moment_waddr;
   logic [MWORD_W-1:0]    moment_wdata;
   logic                  used_we;
   logic [WIDX_W-1:0]     used_idx;
   logic                  used_val;

   // Compare stage: looks at the word read in the previous cycle.
   logic [WIDX_W-1:0]     rd_widx;
   logic                  week_hit;
   logic                  week_rd_free;
   logic                  week_last;
   logic                  new_week_ok;
   logic [WIDX_W-1:0]     new_week_idx;
   logic                  rd_used;
   logic                  mom_hit;
   logic                  mom_last;
   logic                  new_mom_ok;
   logic [CNT_W-1:0]      new_mom_off;
   logic [MADDR_W-1:0]    rd_maddr;

   assign rd_widx      = rd_idx_ff[WIDX_W-1:0];
   assign week_hit     = week_used_ff[rd_widx] && (week_rdata_ff == week_key_ff);
   assign week_rd_free = !week_used_ff[rd_widx];
   assign week_last    = (rd_idx_ff == WEEK_LAST);
   assign new_week_ok  = free_vld_ff || week_rd_free;
   assign new_week_idx = free_vld_ff ? free_idx_ff[WIDX_W-1:0] : rd_widx;

   assign rd_used      = moment_rdata_ff[MOMENT_KEY_W];
   assign mom_hit      = rd_used && (moment_rdata_ff[MOMENT_KEY_W-1:0] == moment_key_ff);
   assign mom_last     = (rd_idx_ff == MOM_LAST);
   assign new_mom_ok   = free_vld_ff || !rd_used;
   assign new_mom_off  = free_vld_ff ? free_idx_ff : rd_idx_ff;
   assign rd_maddr     = base_ff + MADDR_W'(rd_idx_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - STATUS_W)'(0), rsp_status_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         free_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         free_vld_ff  <= free_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      week_key_ff   <= week_key_in;
      moment_key_ff <= moment_key_in;
      rd_idx_ff     <= rd_idx_in;
      free_idx_ff   <= free_idx_in;
      base_ff       <= base_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WEEK_SLOTS; i++) begin
            week_used_ff[i] <= 1'b0;
         end
      end else if (used_we) begin
         week_used_ff[used_idx] <= used_val;
      end
   end

   always_ff @(posedge clock) begin
      if (week_we) begin
         week_mem[week_waddr] <= week_key_ff;
      end
      if (week_rd_en) begin
         week_rdata_ff <= week_mem[week_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (moment_we) begin
         moment_mem[moment_waddr] <= moment_wdata;
      end
      if (moment_rd_en) begin
         moment_rdata_ff <= moment_mem[moment_rd_addr];
      end
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      week_key_in    = week_key_ff;
      moment_key_in  = moment_key_ff;
      cnt_in         = cnt_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      free_vld_in    = free_vld_ff;
      free_idx_in    = free_idx_ff;
      base_in        = base_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      week_rd_en     = 1'b0;
      week_rd_addr   = cnt_ff[WIDX_W-1:0];
      week_we        = 1'b0;
      week_waddr     = new_week_idx;
      moment_rd_en   = 1'b0;
      moment_rd_addr = base_ff + MADDR_W'(cnt_ff);
      moment_we      = 1'b0;
      moment_waddr   = base_ff + MADDR_W'(cnt_ff);
      moment_wdata   = '0;
      used_we        = 1'b0;
      used_idx       = rd_widx;
      used_val       = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // Mark every moment slot free, one per cycle.
            moment_we    = 1'b1;
            moment_waddr = cnt_ff[MADDR_W-1:0];
            moment_wdata = '0;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               kind_in       = req_kind_type'(req_tuser);
               week_key_in   = req_tdata[WEEK_KEY_W-1:0];
               moment_key_in = req_tdata[REQ_TDATA_W-1:WEEK_KEY_W];
               cnt_in        = '0;
               free_vld_in   = 1'b0;
               if (req_kind_type'(req_tuser) == REQ_RESERVED) begin
                  status_in = STS_NOT_FOUND;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_WSCAN;
               end
            end
         end

         S_WSCAN: begin
            // Issue stage: one week slot read per cycle.
            if (cnt_ff < WEEK_CNT) begin
               week_rd_en   = 1'b1;
               week_rd_addr = cnt_ff[WIDX_W-1:0];
               rd_vld_in    = 1'b1;
               rd_idx_in    = cnt_ff;
               cnt_in       = cnt_ff + 1'b1;
            end
            // Compare stage.
            if (rd_vld_ff) begin
               if (week_hit) begin
                  rd_vld_in   = 1'b0;
                  cnt_in      = '0;
                  free_vld_in = 1'b0;
                  base_in     = MADDR_W'(rd_widx) * MOM_STRIDE;
                  if (kind_ff == REQ_DEL_WEEK) begin
                     used_we  = 1'b1;
                     used_idx = rd_widx;
                     used_val = 1'b0;
                     state_in = S_MWIPE;
                  end else begin
                     state_in = S_MSCAN;
                  end
               end else if (week_last) begin
                  rd_vld_in = 1'b0;
                  state_in  = S_RESP;
                  if (kind_ff != REQ_INSERT) begin
                     status_in = STS_NOT_FOUND;
                  end else if (new_week_ok) begin
                     // New week: claim the slot and put the moment in its first entry.
                     // Its moment set is already all free.
                     used_we      = 1'b1;
                     used_idx     = new_week_idx;
                     used_val     = 1'b1;
                     week_we      = 1'b1;
                     week_waddr   = new_week_idx;
                     moment_we    = 1'b1;
                     moment_waddr = MADDR_W'(new_week_idx) * MOM_STRIDE;
                     moment_wdata = {1'b1, moment_key_ff};
                     status_in    = STS_DONE;
                  end else begin
                     status_in = STS_WEEKS_FULL;
                  end
               end else if (!free_vld_ff && week_rd_free) begin
                  free_vld_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
         end

         S_MSCAN: begin
            if (cnt_ff < MOM_CNT) begin
               moment_rd_en   = 1'b1;
               moment_rd_addr = base_ff + MADDR_W'(cnt_ff);
               rd_vld_in      = 1'b1;
               rd_idx_in      = cnt_ff;
               cnt_in         = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (mom_hit) begin
                  rd_vld_in = 1'b0;
                  state_in  = S_RESP;
                  if (kind_ff == REQ_DEL_MOMENT) begin
                     moment_we    = 1'b1;
                     moment_waddr = rd_maddr;
                     moment_wdata = '0;
                     status_in    = STS_DONE;
                  end else begin
                     status_in = STS_OCCUPIED;
                  end
               end else if (mom_last) begin
                  rd_vld_in = 1'b0;
                  state_in  = S_RESP;
                  if (kind_ff == REQ_DEL_MOMENT) begin
                     status_in = STS_NOT_FOUND;
                  end else if (new_mom_ok) begin
                     moment_we    = 1'b1;
                     moment_waddr = base_ff + MADDR_W'(new_mom_off);
                     moment_wdata = {1'b1, moment_key_ff};
                     status_in    = STS_DONE;
                  end else begin
                     status_in = STS_MOMENTS_FULL;
                  end
               end else if (!free_vld_ff && !rd_used) begin
                  free_vld_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
         end

         S_MWIPE: begin
            // Free every moment slot of the deleted week so a new week finds its set empty.
            moment_we    = 1'b1;
            moment_waddr = base_ff + MADDR_W'(cnt_ff);
            moment_wdata = '0;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MOM_LAST) begin
               status_in = STS_DONE;
               state_in  = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // An accepted request always starts work instead of staying in idle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("accepted request did not leave idle");

   // A free week slot remembered during the scan is still free.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WSCAN && free_vld_ff) |-> !week_used_ff[free_idx_ff[WIDX_W-1:0]])
      else $error("remembered free week slot is in use");

   // A finished request waits while the previous response is still held.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_RESP))
      else $error("response overwritten while stalled");

   // A new response appears only out of the response state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the response state");

   // The moment counter never runs past its range in the moment scan and the wipe.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MSCAN || state_ff == S_MWIPE) |-> (cnt_ff <= MOM_CNT))
      else $error("moment counter out of range");

endmodule

/* sim/tslt_status_checker.sv */
// Checker that predicts the status of every table request and compares it with the responses.
`timescale 1ns / 1ps

module tslt_status_checker
   import tslt_pkg::*;
#(
   parameter int WEEK_SLOTS       = WEEK_SLOTS_DEF,
   parameter int MOMENTS_PER_WEEK = MOMENTS_PER_WEEK_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [47:0] week_key, [63:48] moment_key
   input  logic [REQ_TYPE_W-1:0]  req_tuser,  // [1:0] req_type
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,  // [2:0] status, [7:3] zero
   output int                     mismatches,
   output int                     outstanding
);

   localparam int MOMENT_SLOTS = WEEK_SLOTS * MOMENTS_PER_WEEK;

   logic [WEEK_KEY_W-1:0]   week_key_mdl    [WEEK_SLOTS];
   logic                    week_used_mdl   [WEEK_SLOTS];
   logic [MOMENT_KEY_W-1:0] moment_key_mdl  [MOMENT_SLOTS];
   logic                    moment_used_mdl [MOMENT_SLOTS];

   // Statuses still owed by the block, oldest first.
   status_type status_due [$];

   // Offset of the moment within the set of week slot w, or -1 when it is absent.
   function automatic int moment_pos(int w, logic [MOMENT_KEY_W-1:0] mk);
      int pos;
      pos = -1;
      for (int j = 0; j < MOMENTS_PER_WEEK; j++)
         if (pos < 0 && moment_used_mdl[w*MOMENTS_PER_WEEK + j] &&
             moment_key_mdl[w*MOMENTS_PER_WEEK + j] == mk)
            pos = j;
      return pos;
   endfunction

   // Applies one request to the shadow table and returns the status it must produce.
   function automatic status_type table_apply(req_kind_type kind,
                                              logic [WEEK_KEY_W-1:0] wk,
                                              logic [MOMENT_KEY_W-1:0] mk);
      int w;
      int m;
      int base;
      w = -1;
      m = -1;
      for (int i = 0; i < WEEK_SLOTS; i++)
         if (w < 0 && week_used_mdl[i] && week_key_mdl[i] == wk)
            w = i;
      case (kind)
         REQ_INSERT: begin
            if (w < 0) begin
               for (int i = 0; i < WEEK_SLOTS; i++)
                  if (w < 0 && !week_used_mdl[i])
                     w = i;
               if (w < 0)
                  return STS_WEEKS_FULL;
               base = w * MOMENTS_PER_WEEK;
               week_used_mdl[w] = 1'b1;
               week_key_mdl[w]  = wk;
               for (int j = 0; j < MOMENTS_PER_WEEK; j++)
                  moment_used_mdl[base + j] = 1'b0;
               moment_used_mdl[base] = 1'b1;
               moment_key_mdl[base]  = mk;
               return STS_DONE;
            end
            if (moment_pos(w, mk) >= 0)
               return STS_OCCUPIED;
            base = w * MOMENTS_PER_WEEK;
            for (int j = 0; j < MOMENTS_PER_WEEK; j++)
               if (m < 0 && !moment_used_mdl[base + j])
                  m = j;
            if (m < 0)
               return STS_MOMENTS_FULL;
            moment_used_mdl[base + m] = 1'b1;
            moment_key_mdl[base + m]  = mk;
            return STS_DONE;
         end
         REQ_DEL_MOMENT: begin
            if (w < 0)
               return STS_NOT_FOUND;
            m = moment_pos(w, mk);
            if (m < 0)
               return STS_NOT_FOUND;
            moment_used_mdl[w*MOMENTS_PER_WEEK + m] = 1'b0;
            return STS_DONE;
         end
         REQ_DEL_WEEK: begin
            if (w < 0)
               return STS_NOT_FOUND;
            week_used_mdl[w] = 1'b0;
            for (int j = 0; j < MOMENTS_PER_WEEK; j++)
               moment_used_mdl[w*MOMENTS_PER_WEEK + j] = 1'b0;
            return STS_DONE;
         end
         default: return STS_NOT_FOUND;
      endcase
   endfunction

   always @(posedge clock) begin : watch
      status_type want;
      if (reset) begin
         for (int i = 0; i < WEEK_SLOTS; i++)
            week_used_mdl[i] = 1'b0;
         for (int i = 0; i < MOMENT_SLOTS; i++)
            moment_used_mdl[i] = 1'b0;
         status_due.delete();
         mismatches = 0;
      end else begin
         // A response never belongs to the request accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               $error("status: expected none, got %0d", rsp_tdata[STATUS_W-1:0]);
               mismatches++;
            end else begin
               want = status_due.pop_front();
               if (rsp_tdata[STATUS_W-1:0] !== want) begin
                  $error("status: expected %0d, got %0d", want, rsp_tdata[STATUS_W-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[RSP_TDATA_W-1:STATUS_W] !== '0) begin
                  $error("rsp_tdata padding: expected 0, got %0d",
                         rsp_tdata[RSP_TDATA_W-1:STATUS_W]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            status_due.push_back(table_apply(req_kind_type'(req_tuser),
                                             req_tdata[WEEK_KEY_W-1:0],
                                             req_tdata[REQ_TDATA_W-1:WEEK_KEY_W]));
      end
      outstanding = status_due.size();
   end

endmodule

/* sim/tb_two_level_keyed_set_table.sv */
// Testbench top for the two-level keyed set table: stimulus, back-pressure and the verdict.
`timescale 1ns / 1ps

module tb_two_level_keyed_set_table;
   import tslt_pkg::*;

   localparam int WEEK_SLOTS       = WEEK_SLOTS_DEF;
   localparam int MOMENTS_PER_WEEK = MOMENTS_PER_WEEK_DEF;
   // A pool a little larger than either slot count, so that random traffic
   // keeps hitting the same keys and regularly runs both tables full.
   localparam int POOL_SIZE        = 20;
   localparam int ITEMS_PER_PHASE  = 650;
   // Longest request time of the block plus some margin.
   localparam int SETTLE_CYCLES    = WEEK_SLOTS + MOMENTS_PER_WEEK + 8;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TYPE_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatches;
   int outstanding;

   // Percent of cycles in which the request side holds off and the response side stalls.
   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int requests_sent = 0;

   logic [WEEK_KEY_W-1:0]   week_pool   [POOL_SIZE];
   logic [MOMENT_KEY_W-1:0] moment_pool [POOL_SIZE];

   two_level_keyed_set_table #(
      .WEEK_SLOTS       (WEEK_SLOTS),
      .MOMENTS_PER_WEEK (MOMENTS_PER_WEEK)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tslt_status_checker #(
      .WEEK_SLOTS       (WEEK_SLOTS),
      .MOMENTS_PER_WEEK (MOMENTS_PER_WEEK)
   ) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The response side stalls at random; the rate changes with each phase of the run.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= take_idle_pct);

   // The run must never hang: after a generous fixed time it is declared failed.
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [WEEK_KEY_W-1:0] random_week();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Presents one request from a falling edge and holds it until the block takes it.
   // The task returns at the falling edge after acceptance with tvalid still high, so
   // back-to-back requests never lower and raise tvalid within one time step.
   task automatic issue_request(req_kind_type kind, logic [WEEK_KEY_W-1:0] wk,
                                logic [MOMENT_KEY_W-1:0] mk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {mk, wk};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   // Holds off the request side until every status owed has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // New random keys for the pools. The low bits carry the pool index so the
   // entries stay distinct; the first and last entries are the key extremes.
   task automatic refresh_pools();
      logic [WEEK_KEY_W-1:0] wk;
      logic [MOMENT_KEY_W-1:0] mk;
      for (int i = 0; i < POOL_SIZE; i++) begin
         wk = random_week();
         mk = 16'($urandom);
         week_pool[i]   = {wk[WEEK_KEY_W-1:5], 5'(i)};
         moment_pool[i] = {mk[MOMENT_KEY_W-1:5], 5'(i)};
      end
      week_pool[0]             = '0;
      week_pool[POOL_SIZE-1]   = '1;
      moment_pool[0]           = '0;
      moment_pool[POOL_SIZE-1] = '1;
   endtask

   // Deletes every pool week, whether present or not.
   task automatic clear_pool_weeks();
      for (int i = 0; i < POOL_SIZE; i++)
         issue_request(REQ_DEL_WEEK, week_pool[i], 16'($urandom));
   endtask

   // Puts one more distinct moment into a week than its set can hold, so the
   // last insert (at the latest) reports the set full.
   task automatic fill_moment_set();
      int w;
      int start;
      w     = $urandom_range(POOL_SIZE-1);
      start = $urandom_range(POOL_SIZE-1);
      for (int j = 0; j <= MOMENTS_PER_WEEK; j++)
         issue_request(REQ_INSERT, week_pool[w], moment_pool[(start + j) % POOL_SIZE]);
   endtask

   // Inserts into one more distinct week than the table has slots.
   task automatic fill_week_table();
      int start;
      start = $urandom_range(POOL_SIZE-1);
      for (int j = 0; j <= WEEK_SLOTS; j++)
         issue_request(REQ_INSERT, week_pool[(start + j) % POOL_SIZE],
                       moment_pool[$urandom_range(POOL_SIZE-1)]);
   endtask

   // Random traffic until the request count reaches the target. Most of it works on
   // the pools so that keys collide; a tenth is fully random noise, and any week that
   // noise creates is deleted right away so it cannot clog the table for good.
   task automatic run_random(int target);
      int pick;
      int sel;
      req_kind_type kind;
      logic [WEEK_KEY_W-1:0] wk;
      logic [MOMENT_KEY_W-1:0] mk;
      while (requests_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            sel = $urandom_range(99);
            if (sel < 50)
               kind = REQ_INSERT;
            else if (sel < 80)
               kind = REQ_DEL_MOMENT;
            else if (sel < 95)
               kind = REQ_DEL_WEEK;
            else
               kind = REQ_RESERVED;
            mk = (kind == REQ_DEL_WEEK) ? 16'($urandom)
                                        : moment_pool[$urandom_range(POOL_SIZE-1)];
            issue_request(kind, week_pool[$urandom_range(POOL_SIZE-1)], mk);
         end else if (pick < 70) begin
            fill_moment_set();
         end else if (pick < 80) begin
            fill_week_table();
         end else if (pick < 90) begin
            clear_pool_weeks();
         end else begin
            kind = req_kind_type'($urandom_range(3));
            wk   = random_week();
            mk   = 16'($urandom);
            issue_request(kind, wk, mk);
            if (kind == REQ_INSERT)
               issue_request(REQ_DEL_WEEK, wk, mk);
         end
      end
   endtask

   initial begin : stimulus
      logic [WEEK_KEY_W-1:0] week_hi;
      logic [WEEK_KEY_W-1:0] week_lo;
      logic [WEEK_KEY_W-1:0] week_absent;
      week_hi     = '1;
      week_lo     = '0;
      week_absent = random_week() | 48'h1;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one: the request side idles a third of the time, the response side mostly.
      send_idle_pct = 33;
      take_idle_pct = 82;

      // Directed requests. The block first runs its clearing pass; the first
      // request simply waits on tready until that is over.
      issue_request(REQ_INSERT, week_hi, 16'h0000);          // new week on insert
      issue_request(REQ_INSERT, week_hi, 16'h0000);          // duplicate moment
      issue_request(REQ_INSERT, week_hi, 16'hFFFF);          // second moment, same week
      issue_request(REQ_DEL_MOMENT, week_hi, 16'h1234);      // moment missing
      issue_request(REQ_DEL_MOMENT, week_absent, 16'h0000);  // week missing
      issue_request(REQ_DEL_WEEK, week_absent, 16'hFFFF);    // week missing
      issue_request(REQ_RESERVED, week_hi, 16'h0000);        // reserved request type
      issue_request(REQ_RESERVED, week_lo, 16'hFFFF);
      issue_request(REQ_DEL_MOMENT, week_hi, 16'h0000);
      issue_request(REQ_DEL_MOMENT, week_hi, 16'hFFFF);      // last moment goes, week stays
      issue_request(REQ_DEL_MOMENT, week_hi, 16'hFFFF);      // now missing
      issue_request(REQ_INSERT, week_hi, 16'h5A5A);          // refill the empty week
      issue_request(REQ_DEL_WEEK, week_hi, 16'h0000);
      issue_request(REQ_DEL_WEEK, week_hi, 16'h0000);        // already gone
      issue_request(REQ_INSERT, week_lo, 16'hFFFF);
      issue_request(REQ_INSERT, week_lo, 16'h0000);
      issue_request(REQ_DEL_WEEK, week_lo, 16'hA5A5);        // moment field is ignored
      issue_request(REQ_INSERT, week_lo, 16'hFFFF);          // week recreated after delete
      issue_request(REQ_DEL_WEEK, week_lo, 16'h0000);

      // Hold off until every owed status is back before the random part starts.
      wait_for_results();

      for (int phase = 0; phase < 3; phase++) begin
         // Phase two swaps the idle rates; phase three runs without any idling.
         if (phase == 1) begin
            send_idle_pct = 82;
            take_idle_pct = 33;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         if (phase != 0)
            clear_pool_weeks();
         refresh_pools();
         // Each phase opens by running both tables full at least once.
         fill_moment_set();
         fill_week_table();
         clear_pool_weeks();
         run_random((phase + 1) * ITEMS_PER_PHASE);
         wait_for_results();
      end

      // Everything is back; give a stray response time to show up.
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
